### rtl/core/pgp_pkg.sv
// ============================================================================
// pgp_pkg
// Shared constants, types and codes for the planar glyph plotter.
// ============================================================================
`default_nettype none

package pgp_pkg;

    localparam int SCREEN_WIDTH = 320;
    localparam int LINE_BYTES   = 160;
    localparam int PLANES       = 4;
    localparam int GLYPH_ROWS   = 8;
    localparam int GLYPH_COUNT  = 96;
    localparam int FIRST_CODE   = 32;

    localparam int STORE_SIZE = GLYPH_COUNT * GLYPH_ROWS;
    localparam int FA_W       = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
    localparam int PL_W       = (PLANES > 1) ? $clog2(PLANES) : 1;
    localparam int ROW_W      = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;
    localparam int ADDR_W     = 16;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_DRAW = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SINGLE,
        S_FETCH,
        S_EMIT
    } pgp_state_t;

    typedef struct packed {
        logic              we;
        logic [FA_W-1:0]   waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [FA_W-1:0]   raddr;
    } pgp_ram_req_t;

endpackage

`default_nettype wire

### rtl/core/planar_glyph_plotter.sv
// ============================================================================
// planar_glyph_plotter
// Draws 8-pixel-wide font glyphs into an interleaved-bitplane framebuffer as
// masked byte writes, with an internal font store loaded byte by byte.
//
//   channel  direction  handshake               payload
//   in       input      in_valid / in_ready     req_type .. font_data
//   out      output     out_valid / out_ready   write_enable .. last
//
// A drawn character is taken in the idle state, its first row is read in the
// fetch state, then one write goes out per cycle while the output does not
// stall, with the next row read behind the current one. A load, a dropped
// character or one outside the font gives a single non-write result.
// Reset clears the cursor and control state; the font store holds garbage.
// A stalled output holds its result and the sequencer waits on it.
// ============================================================================
`default_nettype none

module planar_glyph_plotter (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        req_type,
    input  wire logic [7:0]  char_code,
    input  wire logic        first_of_string,
    input  wire logic [8:0]  start_x,
    input  wire logic [7:0]  start_y,
    input  wire logic [3:0]  pen,
    input  wire logic [9:0]  font_address,
    input  wire logic [7:0]  font_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             write_enable,
    output logic [15:0]      byte_address,
    output logic [7:0]       write_data,
    output logic [7:0]       write_mask,
    output logic [8:0]       cursor_x,
    output logic             last
);

    pgp_pkg::pgp_ram_req_t ram_req;
    logic [7:0]            ram_rdata;

    pgp_font_ram u_font_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    pgp_sequencer u_sequencer (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .req_type        (req_type),
        .char_code       (char_code),
        .first_of_string (first_of_string),
        .start_x         (start_x),
        .start_y         (start_y),
        .pen             (pen),
        .font_address    (font_address),
        .font_data       (font_data),
        .ram_req         (ram_req),
        .ram_rdata       (ram_rdata),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .write_enable    (write_enable),
        .byte_address    (byte_address),
        .write_data      (write_data),
        .write_mask      (write_mask),
        .cursor_x        (cursor_x),
        .last            (last)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_req.we && ram_req.re))
        else $error("Font store read and write in the same cycle.");

    assert property (@(posedge clk) disable iff (!rst_n)
        ram_req.we |-> (in_valid && in_ready && req_type == pgp_pkg::REQ_LOAD))
        else $error("Font store written outside a load transfer.");

    assert property (@(posedge clk) disable iff (!rst_n)
        ram_req.re |-> !in_ready)
        else $error("Font store read while the input side is open.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !write_enable) |-> (last && byte_address == 16'd0))
        else $error("Non-write result is not a lone final result.");

endmodule

`default_nettype wire

### rtl/core/pgp_font_ram.sv
// ============================================================================
// pgp_font_ram
// Font store: one write port and one read port with registered read data.
// ============================================================================
`default_nettype none

module pgp_font_ram (
    input  wire logic                  clk,
    input  wire pgp_pkg::pgp_ram_req_t req,
    output logic [7:0]                 rdata
);

    logic [7:0] mem [pgp_pkg::STORE_SIZE];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/core/pgp_sequencer.sv
// ============================================================================
// pgp_sequencer
// Takes items, keeps the cursor, walks glyph rows and planes and drives the
// output register with one masked byte write per cycle unless it stalls.
// ============================================================================
`default_nettype none

module pgp_sequencer (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic                   req_type,
    input  wire logic [7:0]             char_code,
    input  wire logic                   first_of_string,
    input  wire logic [8:0]             start_x,
    input  wire logic [7:0]             start_y,
    input  wire logic [3:0]             pen,
    input  wire logic [9:0]             font_address,
    input  wire logic [7:0]             font_data,
    output pgp_pkg::pgp_ram_req_t       ram_req,
    input  wire logic [7:0]             ram_rdata,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic                        write_enable,
    output logic [15:0]                 byte_address,
    output logic [7:0]                  write_data,
    output logic [7:0]                  write_mask,
    output logic [8:0]                  cursor_x,
    output logic                        last
);

    localparam logic [8:0] CODE_END = 9'(pgp_pkg::FIRST_CODE + pgp_pkg::GLYPH_COUNT);
    localparam logic [8:0] CODE_BEG = 9'(pgp_pkg::FIRST_CODE);

    pgp_pkg::pgp_state_t state_reg, state_next;
    logic [8:0]                     cursor_col_reg, cursor_col_next;
    logic [7:0]                     cursor_line_reg, cursor_line_next;
    logic [pgp_pkg::ADDR_W-1:0]     row_addr_reg, row_addr_next;
    logic [pgp_pkg::ADDR_W-1:0]     plane_addr_reg, plane_addr_next;
    logic [pgp_pkg::FA_W-1:0]       font_addr_reg, font_addr_next;
    logic [7:0]                     row_bits_reg, row_bits_next;
    logic [3:0]                     pen_reg, pen_next;
    logic [pgp_pkg::PL_W-1:0]       plane_cnt_reg, plane_cnt_next;
    logic [pgp_pkg::ROW_W-1:0]      row_cnt_reg, row_cnt_next;
    logic                           out_valid_reg, out_valid_next;
    logic                           out_we_reg, out_we_next;
    logic [15:0]                    out_addr_reg, out_addr_next;
    logic [7:0]                     out_data_reg, out_data_next;
    logic [7:0]                     out_mask_reg, out_mask_next;
    logic [8:0]                     out_cur_reg, out_cur_next;
    logic                           out_last_reg, out_last_next;

    logic                           can_load;
    logic [8:0]                     x_sel;
    logic [7:0]                     line_sel;
    logic [7:0]                     glyph_idx;
    logic [7:0]                     bits;
    logic [7:0]                     pen_wide;
    logic                           last_row;
    logic                           last_plane;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= pgp_pkg::S_IDLE;
            cursor_col_reg  <= '0;
            cursor_line_reg <= '0;
            plane_cnt_reg   <= '0;
            row_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cursor_col_reg  <= cursor_col_next;
            cursor_line_reg <= cursor_line_next;
            plane_cnt_reg   <= plane_cnt_next;
            row_cnt_reg     <= row_cnt_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_addr_reg   <= row_addr_next;
        plane_addr_reg <= plane_addr_next;
        font_addr_reg  <= font_addr_next;
        row_bits_reg   <= row_bits_next;
        pen_reg        <= pen_next;
        out_we_reg     <= out_we_next;
        out_addr_reg   <= out_addr_next;
        out_data_reg   <= out_data_next;
        out_mask_reg   <= out_mask_next;
        out_cur_reg    <= out_cur_next;
        out_last_reg   <= out_last_next;
    end

    assign can_load   = !out_valid_reg || out_ready;
    assign x_sel      = first_of_string ? {start_x[8:3], 3'b000} : cursor_col_reg;
    assign line_sel   = first_of_string ? start_y : cursor_line_reg;
    assign glyph_idx  = char_code - 8'(pgp_pkg::FIRST_CODE);
    assign bits       = (plane_cnt_reg == '0) ? ram_rdata : row_bits_reg;
    assign pen_wide   = 8'(pen_reg);
    assign last_row   = row_cnt_reg == pgp_pkg::ROW_W'(pgp_pkg::GLYPH_ROWS - 1);
    assign last_plane = plane_cnt_reg == pgp_pkg::PL_W'(pgp_pkg::PLANES - 1);

    always_comb
    begin
        state_next       = state_reg;
        cursor_col_next  = cursor_col_reg;
        cursor_line_next = cursor_line_reg;
        row_addr_next    = row_addr_reg;
        plane_addr_next  = plane_addr_reg;
        font_addr_next   = font_addr_reg;
        row_bits_next    = row_bits_reg;
        pen_next         = pen_reg;
        plane_cnt_next   = plane_cnt_reg;
        row_cnt_next     = row_cnt_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_we_next      = out_we_reg;
        out_addr_next    = out_addr_reg;
        out_data_next    = out_data_reg;
        out_mask_next    = out_mask_reg;
        out_cur_next     = out_cur_reg;
        out_last_next    = out_last_reg;
        ram_req          = '0;
        in_ready         = 1'b0;

        unique case (state_reg)
            pgp_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (req_type == pgp_pkg::REQ_LOAD)
                    begin
                        ram_req.we    = 32'(font_address) < pgp_pkg::STORE_SIZE;
                        ram_req.waddr = pgp_pkg::FA_W'(font_address);
                        ram_req.wdata = font_data;
                        state_next    = pgp_pkg::S_SINGLE;
                    end
                    else
                    begin
                        cursor_col_next  = x_sel;
                        cursor_line_next = line_sel;
                        state_next       = pgp_pkg::S_SINGLE;
                        if ((11'(x_sel) + 11'd8) <= 11'(pgp_pkg::SCREEN_WIDTH))
                        begin
                            cursor_col_next = x_sel + 9'd8;
                            if ({1'b0, char_code} >= CODE_BEG
                                && {1'b0, char_code} < CODE_END)
                            begin
                                state_next     = pgp_pkg::S_FETCH;
                                font_addr_next = pgp_pkg::FA_W'(32'(glyph_idx)
                                                 * pgp_pkg::GLYPH_ROWS);
                                row_addr_next  = pgp_pkg::ADDR_W'(
                                    32'(line_sel) * pgp_pkg::LINE_BYTES
                                    + 32'(x_sel[8:4]) * (2 * pgp_pkg::PLANES)
                                    + 32'(x_sel[3]));
                                plane_addr_next = pgp_pkg::ADDR_W'(
                                    32'(line_sel) * pgp_pkg::LINE_BYTES
                                    + 32'(x_sel[8:4]) * (2 * pgp_pkg::PLANES)
                                    + 32'(x_sel[3]));
                                pen_next       = pen;
                                plane_cnt_next = '0;
                                row_cnt_next   = '0;
                            end
                        end
                    end
                end
            end

            pgp_pkg::S_SINGLE:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    out_we_next    = 1'b0;
                    out_addr_next  = '0;
                    out_data_next  = '0;
                    out_mask_next  = '0;
                    out_cur_next   = cursor_col_reg;
                    out_last_next  = 1'b1;
                    state_next     = pgp_pkg::S_IDLE;
                end
            end

            pgp_pkg::S_FETCH:
            begin
                ram_req.re     = 1'b1;
                ram_req.raddr  = font_addr_reg;
                font_addr_next = font_addr_reg + pgp_pkg::FA_W'(1);
                state_next     = pgp_pkg::S_EMIT;
            end

            pgp_pkg::S_EMIT:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    out_we_next    = 1'b1;
                    out_addr_next  = plane_addr_reg;
                    out_data_next  = pen_wide[3'(plane_cnt_reg)] ? bits : 8'd0;
                    out_mask_next  = bits;
                    out_cur_next   = cursor_col_reg;
                    out_last_next  = last_row && last_plane;
                    // The next row is fetched while this row's planes go out.
                    if (plane_cnt_reg == '0)
                    begin
                        row_bits_next = ram_rdata;
                        if (!last_row)
                        begin
                            ram_req.re     = 1'b1;
                            ram_req.raddr  = font_addr_reg;
                            font_addr_next = font_addr_reg + pgp_pkg::FA_W'(1);
                        end
                    end
                    if (last_plane)
                    begin
                        plane_cnt_next  = '0;
                        row_cnt_next    = row_cnt_reg + pgp_pkg::ROW_W'(1);
                        row_addr_next   = row_addr_reg
                                          + pgp_pkg::ADDR_W'(pgp_pkg::LINE_BYTES);
                        plane_addr_next = row_addr_reg
                                          + pgp_pkg::ADDR_W'(pgp_pkg::LINE_BYTES);
                        if (last_row)
                        begin
                            state_next = pgp_pkg::S_IDLE;
                        end
                    end
                    else
                    begin
                        plane_cnt_next  = plane_cnt_reg + pgp_pkg::PL_W'(1);
                        plane_addr_next = plane_addr_reg + pgp_pkg::ADDR_W'(2);
                    end
                end
            end

            default:
            begin
                state_next = pgp_pkg::S_IDLE;
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign write_enable = out_we_reg;
    assign byte_address = out_addr_reg;
    assign write_data   = out_data_reg;
    assign write_mask   = out_mask_reg;
    assign cursor_x     = out_cur_reg;
    assign last         = out_last_reg;

endmodule

`default_nettype wire

### dv/plot_check_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Glyph plotter scoreboard
// Keeps a copy of the font store and the text cursor, works out the
// framebuffer writes that each accepted request must cause, and compares the
// writes that leave the block against them in order.
// ----------------------------------------------------------------------------
package plot_check_pkg;

    import pgp_pkg::*;

    typedef struct packed {
        logic       req_type;
        logic [7:0] char_code;
        logic       first_of_string;
        logic [8:0] start_x;
        logic [7:0] start_y;
        logic [3:0] pen;
        logic [9:0] font_address;
        logic [7:0] font_data;
    } glyph_req_t;

    typedef struct packed {
        logic        write_enable;
        logic [15:0] byte_address;
        logic [7:0]  write_data;
        logic [7:0]  write_mask;
        logic [8:0]  cursor_x;
        logic        last;
    } fb_write_t;

    class glyph_write_scoreboard;

        logic [7:0] font_rows [STORE_SIZE];
        logic [8:0] col;
        logic [7:0] line_no;
        fb_write_t  queued_writes [$];
        int         errors;

        function new();
            col = '0;
            line_no = '0;
            errors = 0;
        endfunction

        function int pending();
            return queued_writes.size();
        endfunction

        function void queue_write(bit we, logic [15:0] addr, logic [7:0] data,
                                  logic [7:0] mask, bit is_last);
            fb_write_t w;
            w.write_enable = we;
            w.byte_address = addr;
            w.write_data = data;
            w.write_mask = mask;
            w.cursor_x = col;
            w.last = is_last;
            queued_writes.push_back(w);
        endfunction

        function void note_request(glyph_req_t rq);
            int unsigned x;
            int unsigned base;
            int unsigned line_addr;
            logic [7:0]  bits;
            if (rq.req_type == REQ_LOAD)
            begin
                if (rq.font_address < STORE_SIZE)
                begin
                    font_rows[rq.font_address] = rq.font_data;
                end
                queue_write(1'b0, '0, '0, '0, 1'b1);
                return;
            end
            if (rq.first_of_string)
            begin
                col = {rq.start_x[8:3], 3'b000};
                line_no = rq.start_y;
            end
            x = 32'(col);
            if (x + 8 > SCREEN_WIDTH)
            begin
                queue_write(1'b0, '0, '0, '0, 1'b1);
                return;
            end
            col = col + 9'd8;
            if (rq.char_code < FIRST_CODE || rq.char_code >= FIRST_CODE + GLYPH_COUNT)
            begin
                queue_write(1'b0, '0, '0, '0, 1'b1);
                return;
            end
            base = (x >> 4) * 2 * PLANES + ((x >> 3) & 1);
            for (int row = 0; row < GLYPH_ROWS; row++)
            begin
                bits = font_rows[(rq.char_code - FIRST_CODE) * GLYPH_ROWS + row];
                line_addr = (32'(line_no) + row) * LINE_BYTES + base;
                for (int plane = 0; plane < PLANES; plane++)
                begin
                    queue_write(1'b1, 16'(line_addr + 2 * plane),
                                rq.pen[plane] ? bits : 8'h00, bits,
                                row == GLYPH_ROWS - 1 && plane == PLANES - 1);
                end
            end
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            end
        endfunction

        function void check_write(fb_write_t got);
            fb_write_t want;
            if (queued_writes.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected write transfer, expected none actual %h", $time, got);
                return;
            end
            want = queued_writes.pop_front();
            compare_field("write_enable", want.write_enable, got.write_enable);
            compare_field("byte_address", want.byte_address, got.byte_address);
            compare_field("write_data", want.write_data, got.write_data);
            compare_field("write_mask", want.write_mask, got.write_mask);
            compare_field("cursor_x", want.cursor_x, got.cursor_x);
            compare_field("last", want.last, got.last);
        endfunction

    endclass

endpackage

### dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Planar glyph plotter testbench
// Loads glyphs into the font store and draws strings of characters across the
// screen, with random idle cycles on the request side and random stalls on
// the write side. Every write transfer is checked against the scoreboard.
// ----------------------------------------------------------------------------
module tb_top;

    import pgp_pkg::*;
    import plot_check_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 430;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        req_type;
    logic [7:0]  char_code;
    logic        first_of_string;
    logic [8:0]  start_x;
    logic [7:0]  start_y;
    logic [3:0]  pen;
    logic [9:0]  font_address;
    logic [7:0]  font_data;
    logic        out_valid;
    logic        out_ready;
    logic        write_enable;
    logic [15:0] byte_address;
    logic [7:0]  write_data;
    logic [7:0]  write_mask;
    logic [8:0]  cursor_x;
    logic        last;

    glyph_write_scoreboard sb = new();
    bit entry_loaded [STORE_SIZE];
    int send_idle_pct = 23;
    int recv_stall_pct = 57;
    int idle_cycles = 0;
    int items_sent = 0;

    planar_glyph_plotter dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        out_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            sb.check_write({write_enable, byte_address, write_data, write_mask, cursor_x, last});
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("[planar_glyph_plotter] ERROR");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic glyph_req_t random_fields();
        glyph_req_t rq;
        rq.req_type = 1'($urandom_range(1));
        rq.char_code = 8'($urandom_range(255));
        rq.first_of_string = 1'($urandom_range(1));
        rq.start_x = 9'($urandom_range(319));
        rq.start_y = 8'($urandom_range(255));
        rq.pen = 4'($urandom_range(15));
        rq.font_address = 10'($urandom_range(1023));
        rq.font_data = 8'($urandom_range(255));
        return rq;
    endfunction

    function automatic glyph_req_t load_req(int addr, int data);
        glyph_req_t rq;
        rq = random_fields();
        rq.req_type = REQ_LOAD;
        rq.font_address = 10'(addr);
        rq.font_data = 8'(data);
        return rq;
    endfunction

    function automatic glyph_req_t draw_req(int code, bit restart, int sx, int sy, int pen_bits);
        glyph_req_t rq;
        rq = random_fields();
        rq.req_type = REQ_DRAW;
        rq.char_code = 8'(code);
        rq.first_of_string = restart;
        rq.start_x = 9'(sx);
        rq.start_y = 8'(sy);
        rq.pen = 4'(pen_bits);
        return rq;
    endfunction

    function automatic bit glyph_ready(int g);
        for (int row = 0; row < GLYPH_ROWS; row++)
        begin
            if (!entry_loaded[g * GLYPH_ROWS + row])
            begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // Characters inside the font are only drawn once their whole glyph is loaded.
    function automatic int pick_code();
        int ready_glyphs [$];
        for (int g = 0; g < GLYPH_COUNT; g++)
        begin
            if (glyph_ready(g))
            begin
                ready_glyphs.push_back(g);
            end
        end
        if (ready_glyphs.size() != 0 && $urandom_range(99) < 85)
        begin
            return ready_glyphs[$urandom_range(ready_glyphs.size() - 1)] + FIRST_CODE;
        end
        if ($urandom_range(1))
        begin
            return $urandom_range(FIRST_CODE - 1);
        end
        return $urandom_range(255, FIRST_CODE + GLYPH_COUNT);
    endfunction

    task automatic send_request(glyph_req_t rq);
        in_valid <= 1'b1;
        req_type <= rq.req_type;
        char_code <= rq.char_code;
        first_of_string <= rq.first_of_string;
        start_x <= rq.start_x;
        start_y <= rq.start_y;
        pen <= rq.pen;
        font_address <= rq.font_address;
        font_data <= rq.font_data;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        sb.note_request(rq);
        if (rq.req_type == REQ_LOAD && rq.font_address < STORE_SIZE)
        begin
            entry_loaded[rq.font_address] = 1'b1;
        end
        items_sent++;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic load_glyph(int g);
        int first_row;
        first_row = $urandom_range(GLYPH_ROWS - 1);
        for (int k = 0; k < GLYPH_ROWS; k++)
        begin
            send_request(load_req(g * GLYPH_ROWS + (first_row + k) % GLYPH_ROWS,
                                  $urandom_range(255)));
        end
    endtask

    task automatic draw_string();
        int count;
        count = $urandom_range(12, 1);
        send_request(draw_req(pick_code(), 1'b1, $urandom_range(319), $urandom_range(255),
                              $urandom_range(15)));
        repeat (count)
        begin
            send_request(draw_req(pick_code(), 1'b0, $urandom_range(319), $urandom_range(255),
                                  $urandom_range(15)));
        end
    endtask

    task automatic run_random(int count);
        int target;
        int pick;
        target = items_sent + count;
        while (items_sent < target)
        begin
            pick = $urandom_range(99);
            if (pick < 20)
            begin
                load_glyph($urandom_range(GLYPH_COUNT - 1));
            end
            else if (pick < 80)
            begin
                draw_string();
            end
            else if (pick < 90)
            begin
                send_request(load_req($urandom_range(1023), $urandom_range(255)));
            end
            else
            begin
                send_request(draw_req(pick_code(), $urandom_range(1), $urandom_range(319),
                                      $urandom_range(255), $urandom_range(15)));
            end
        end
    endtask

    initial
    begin
        logic [7:0] first_glyph [GLYPH_ROWS];
        first_glyph = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'hAA, 8'h55, 8'h3C, 8'hC3};
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        req_type <= REQ_LOAD;
        char_code <= '0;
        first_of_string <= 1'b0;
        start_x <= '0;
        start_y <= '0;
        pen <= '0;
        font_address <= '0;
        font_data <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(load_req(STORE_SIZE, 8'hFF));
        send_request(load_req(1023, 8'hFF));
        for (int row = 0; row < GLYPH_ROWS; row++)
        begin
            send_request(load_req(row, first_glyph[row]));
        end
        for (int row = 0; row < GLYPH_ROWS; row++)
        begin
            send_request(load_req((GLYPH_COUNT - 1) * GLYPH_ROWS + row, ~first_glyph[row]));
        end
        send_request(draw_req(FIRST_CODE, 1'b1, 0, 0, 4'h0));
        send_request(draw_req(FIRST_CODE + GLYPH_COUNT - 1, 1'b0, 0, 0, 4'hF));
        send_request(draw_req(FIRST_CODE - 1, 1'b0, 0, 0, 4'hF));
        send_request(draw_req(FIRST_CODE + GLYPH_COUNT, 1'b0, 0, 0, 4'hF));
        send_request(draw_req(FIRST_CODE + GLYPH_COUNT - 1, 1'b1, 319, 255, 4'hA));
        send_request(draw_req(FIRST_CODE, 1'b0, 0, 0, 4'hF));
        send_request(draw_req(255, 1'b0, 0, 0, 4'hF));
        send_request(draw_req(FIRST_CODE, 1'b1, 7, 128, 4'h5));
        drain_results();

        run_random(RANDOM_ITEMS / 3);
        drain_results();
        send_idle_pct = 57;
        recv_stall_pct = 23;
        run_random(RANDOM_ITEMS / 3);
        drain_results();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        run_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
        drain_results();
        repeat (40) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("[planar_glyph_plotter] OK");
        end
        else
        begin
            $display("[planar_glyph_plotter] ERROR");
        end
        $finish;
    end

endmodule
